// ===== rtl/lrsa_pkg.sv =====
// Shared types and constants for the eight-lane Lehmer generator.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package lrsa_pkg;

	localparam int LANES = 8;
	localparam logic [30:0] MOD_M = 31'h7FFF_FFFF;
	localparam logic [30:0] MULT_RESET = 31'd48271;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		OP_SEED = 2'd0,
		OP_GEN  = 2'd1,
		OP_SKIP = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [63:0] value;
	} cmd_t;

	typedef logic [LANES-1:0][30:0] lane_vec_t;

	typedef struct packed {
		logic        start;
		logic [30:0] base;
		logic [63:0] exponent;
	} pow_ctl_t;

	typedef struct packed {
		logic        busy;
		logic [30:0] result;
	} pow_st_t;

endpackage

// ===== rtl/lrsa_channels.sv =====
// Valid/ready channel interfaces: command items in, eight-lane results out.
// Depends on lrsa_pkg.
`timescale 1ns / 1ps

interface lrsa_item_if import lrsa_pkg::*; ();
	logic        valid;
	logic        ready;
	op_t         operation;
	logic [63:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink (input valid, input operation, input value, output ready);
endinterface

interface lrsa_result_if;
	logic        valid;
	logic        ready;
	logic [30:0] lane0;
	logic [30:0] lane1;
	logic [30:0] lane2;
	logic [30:0] lane3;
	logic [30:0] lane4;
	logic [30:0] lane5;
	logic [30:0] lane6;
	logic [30:0] lane7;

	modport source (output valid, output lane0, output lane1, output lane2, output lane3,
		output lane4, output lane5, output lane6, output lane7, input ready);
	modport sink (input valid, input lane0, input lane1, input lane2, input lane3,
		input lane4, input lane5, input lane6, input lane7, output ready);
endinterface

// ===== rtl/lehmer_rng_eight_lane_skipahead.sv =====
// Top level of the eight-lane Lehmer generator with skip-ahead.
// Depends on lrsa_pkg, lrsa_channels, lrsa_front and lrsa_back.
`timescale 1ns / 1ps

// Usage:
//   items   : command channel (operation, value). Seed (0), generate (1),
//             skip (2); opcode 3 is taken and discarded.
//   results : one transfer per generate, lanes 0..7 before the advance.
//   cfg_we / cfg_wdata : multiplier register, write only while idle.
// Timing:
//   A two-entry queue sits between the command port and the sequencer.
//   Generate: each item goes through the eight lane multipliers
//   (product register, then fold); its result is registered as the
//   sequencer takes the command, and the next command waits for idle.
//   Seed: eight dependent multiply steps, each a multiply and a write state.
//   Skip: the square-and-multiply power unit raises the multiplier to the
//   power offset*8 (at most 64 bits long), then the lanes take the product.
// Reset: all lanes and the jump multiplier are 1, multiplier is 48271,
//   queue and result register empty.
// Stall: a pending result holds in its register; the queue keeps taking
//   commands until full, and a generate waits while the sequencer is busy
//   or while the result register is occupied and not being taken.

module lehmer_rng_eight_lane_skipahead import lrsa_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [30:0]   cfg_wdata,
	lrsa_item_if.sink     items,
	lrsa_result_if.source results
);

	cmd_t head;
	logic head_valid;
	logic head_ready;

	lrsa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.head       (head),
		.head_valid (head_valid),
		.head_ready (head_ready)
	);

	lrsa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.head       (head),
		.head_valid (head_valid),
		.head_ready (head_ready),
		.results    (results)
	);

endmodule

// ===== rtl/lrsa_front.sv =====
// Front end: takes command transfers, drops unused opcodes, queues the rest.
// Depends on lrsa_pkg and lrsa_channels.
`timescale 1ns / 1ps

module lrsa_front import lrsa_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	lrsa_item_if.sink    items,
	output cmd_t         head,
	output logic         head_valid,
	input  logic         head_ready
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	cmd_t            queue_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;
	logic            push;
	logic            pop;

	assign items.ready = (count_q != (PW+1)'(QUEUE_DEPTH));
	assign push        = items.valid && items.ready && (items.operation != OP_NONE);
	assign head_valid  = (count_q != '0);
	assign pop         = head_valid && head_ready;
	assign head        = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= '{op: items.operation, value: items.value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/lrsa_mulmod.sv =====
// Multiply modulo 2^31-1: registered 62-bit product, then two folds and a
// final subtract. Depends on lrsa_pkg.
`timescale 1ns / 1ps

module lrsa_mulmod import lrsa_pkg::*; (
	input  logic        clk,
	input  logic [30:0] p,
	input  logic [30:0] q,
	output logic [30:0] r
);

	logic [61:0] prod_s1;
	logic [31:0] fold1;
	logic [31:0] fold2;

	always_ff @(posedge clk) begin
		prod_s1 <= {31'b0, p} * {31'b0, q};
	end

	always_comb begin
		fold1 = {1'b0, prod_s1[30:0]} + {1'b0, prod_s1[61:31]};
		fold2 = {1'b0, fold1[30:0]} + {31'b0, fold1[31]};
		if (fold2 >= {1'b0, MOD_M}) begin
			r = 31'(fold2 - {1'b0, MOD_M});
		end else begin
			r = fold2[30:0];
		end
	end

endmodule

// ===== rtl/lrsa_pow.sv =====
// Modular power unit: square-and-multiply, one exponent bit per multiply step,
// with separate multipliers for the accumulator and the square.
// Depends on lrsa_pkg and lrsa_mulmod.
`timescale 1ns / 1ps

module lrsa_pow import lrsa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  pow_ctl_t ctl,
	output pow_st_t  st
);

	logic [30:0] r_q;
	logic [30:0] b_q;
	logic [63:0] e_q;
	logic        busy_q;
	logic        phase_q;
	logic [30:0] rb;
	logic [30:0] bb;

	lrsa_mulmod u_mul_rb (.clk(clk), .p(r_q), .q(b_q), .r(rb));
	lrsa_mulmod u_mul_bb (.clk(clk), .p(b_q), .q(b_q), .r(bb));

	assign st.busy   = busy_q;
	assign st.result = r_q;

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			r_q <= 31'd1;
			b_q <= ctl.base;
			e_q <= ctl.exponent;
		end else if (busy_q && phase_q) begin
			if (e_q[0]) begin
				r_q <= rb;
			end
			b_q <= bb;
			e_q <= {1'b0, e_q[63:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
		end else if (ctl.start) begin
			busy_q  <= 1'b1;
			phase_q <= 1'b0;
		end else if (busy_q) begin
			if (!phase_q) begin
				if (e_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					phase_q <= 1'b1;
				end
			end else begin
				phase_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/lrsa_back.sv =====
// Back end: lane state, multiplier register, sequencer for seed, generate and
// skip, and the result register. Depends on lrsa_pkg, lrsa_channels,
// lrsa_mulmod and lrsa_pow.
`timescale 1ns / 1ps

module lrsa_back import lrsa_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [30:0]   cfg_wdata,
	input  cmd_t          head,
	input  logic          head_valid,
	output logic          head_ready,
	lrsa_result_if.source results
);

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_SEED_MUL = 7'b0000010,
		ST_SEED_WR  = 7'b0000100,
		ST_SEED_JMP = 7'b0001000,
		ST_GEN_WR   = 7'b0010000,
		ST_SKIP_POW = 7'b0100000,
		ST_SKIP_WR  = 7'b1000000
	} state_t;

	state_t      state_q;
	lane_vec_t   lane_q;
	lane_vec_t   lane_prod;
	lane_vec_t   res_q;
	logic        res_valid_q;
	logic [30:0] jump_q;
	logic [30:0] mult_q;
	logic [2:0]  step_q;
	logic [30:0] a_red;
	logic [30:0] opnd;
	logic [31:0] seed_sum;
	logic [30:0] seed_red;
	logic [30:0] seed_init;
	logic        out_free;
	logic        take;
	pow_ctl_t    pow_ctl;
	pow_st_t     pow_st;

	assign a_red = (mult_q == MOD_M) ? 31'd0 : mult_q;

	always_comb begin
		seed_sum = {1'b0, head.value[30:0]} + {31'b0, head.value[31]};
		if (seed_sum >= {1'b0, MOD_M}) begin
			seed_red = 31'(seed_sum - {1'b0, MOD_M});
		end else begin
			seed_red = seed_sum[30:0];
		end
		seed_init = (seed_red == '0) ? 31'd1 : seed_red;
	end

	always_comb begin
		case (state_q)
			ST_SEED_MUL: opnd = a_red;
			ST_SKIP_POW: opnd = pow_st.result;
			default:     opnd = jump_q;
		endcase
	end

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		lrsa_mulmod u_mul (.clk(clk), .p(lane_q[k]), .q(opnd), .r(lane_prod[k]));
	end

	assign out_free   = !res_valid_q || results.ready;
	assign head_ready = (state_q == ST_IDLE) && ((head.op != OP_GEN) || out_free);
	assign take       = head_valid && head_ready;

	always_comb begin
		pow_ctl.start    = take && (head.op == OP_SEED || head.op == OP_SKIP);
		pow_ctl.base     = a_red;
		pow_ctl.exponent = (head.op == OP_SEED) ? 64'd8 : {head.value[60:0], 3'b000};
	end

	lrsa_pow u_pow (.clk(clk), .arst_n(arst_n), .ctl(pow_ctl), .st(pow_st));

	assign results.valid = res_valid_q;
	assign results.lane0 = res_q[0];
	assign results.lane1 = res_q[1];
	assign results.lane2 = res_q[2];
	assign results.lane3 = res_q[3];
	assign results.lane4 = res_q[4];
	assign results.lane5 = res_q[5];
	assign results.lane6 = res_q[6];
	assign results.lane7 = res_q[7];

	always_ff @(posedge clk) begin
		if (take && head.op == OP_GEN) begin
			res_q <= lane_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			step_q      <= '0;
			mult_q      <= MULT_RESET;
			jump_q      <= 31'd1;
			for (int k = 0; k < LANES; k++) begin
				lane_q[k] <= 31'd1;
			end
		end else begin
			if (cfg_we) begin
				mult_q <= cfg_wdata;
			end
			if (take && head.op == OP_GEN) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						case (head.op)
							OP_SEED: begin
								for (int k = 0; k < LANES; k++) begin
									lane_q[k] <= seed_init;
								end
								step_q  <= '0;
								state_q <= ST_SEED_MUL;
							end
							OP_GEN:  state_q <= ST_GEN_WR;
							OP_SKIP: state_q <= ST_SKIP_POW;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SEED_MUL: state_q <= ST_SEED_WR;
				ST_SEED_WR: begin
					// lane k takes k+1 multiplies by a
					for (int k = 0; k < LANES; k++) begin
						if (3'(k) >= step_q) begin
							lane_q[k] <= lane_prod[k];
						end
					end
					if (step_q == 3'(LANES-1)) begin
						state_q <= ST_SEED_JMP;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= ST_SEED_MUL;
					end
				end
				ST_SEED_JMP: begin
					if (!pow_st.busy) begin
						jump_q  <= pow_st.result;
						state_q <= ST_IDLE;
					end
				end
				ST_GEN_WR: begin
					lane_q  <= lane_prod;
					state_q <= ST_IDLE;
				end
				ST_SKIP_POW: begin
					if (!pow_st.busy) begin
						state_q <= ST_SKIP_WR;
					end
				end
				ST_SKIP_WR: begin
					lane_q  <= lane_prod;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_pow_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pow_ctl.start |-> !pow_st.busy)
		else $error("power unit restarted while busy");
	a_res_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_IDLE))
		else $error("result raised outside a generate transfer");
	a_gen_has_res: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_GEN_WR |-> res_valid_q)
		else $error("generate advancing lanes without a pending result");
	a_skip_wait_stable: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SKIP_POW |=> $stable(lane_q))
		else $error("lanes changed while waiting on skip power");
	a_seed_chain_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEED_JMP |-> step_q == 3'(LANES-1))
		else $error("seed chain ended early");
`endif

endmodule

// ===== bench/tb_lehmer_rng_eight_lane_skipahead.sv =====
// Self-checking bench for the eight-lane Lehmer generator with skip-ahead.
// Uses lrsa_pkg and the lrsa_channels interfaces; drives seed, generate and skip
// commands with random gaps and stalls, and checks every lane of every result.
`timescale 1ns / 1ps

module tb_lehmer_rng_eight_lane_skipahead import lrsa_pkg::*; ();

	class lehmer_scoreboard;
		logic [30:0] lanes [LANES];
		logic [30:0] jump_step;
		logic [30:0] mult;
		lane_vec_t   expected_lanes [$];
		int          errors;
		int          n_seed;
		int          n_gen;
		int          n_skip;
		int          n_ignored;

		function new();
			for (int k = 0; k < LANES; k++) lanes[k] = 31'd1;
			jump_step = 31'd1;
			mult = MULT_RESET;
			errors = 0;
			n_seed = 0;
			n_gen = 0;
			n_skip = 0;
			n_ignored = 0;
		endfunction

		function logic [30:0] fold31(logic [63:0] x);
			logic [63:0] s;
			s = {33'd0, x[30:0]} + (x >> 31);
			s = {33'd0, s[30:0]} + (s >> 31);
			if (s >= {33'd0, MOD_M}) s = s - {33'd0, MOD_M};
			return s[30:0];
		endfunction

		function logic [30:0] mulmod(logic [30:0] a, logic [30:0] b);
			return fold31({33'd0, a} * {33'd0, b});
		endfunction

		function logic [30:0] powmod(logic [30:0] base, logic [63:0] e);
			logic [30:0] r;
			logic [30:0] b;
			r = 31'd1;
			b = fold31({33'd0, base});
			for (int i = 0; i < 64; i++) begin
				if (e[i]) r = mulmod(r, b);
				b = mulmod(b, b);
			end
			return r;
		endfunction

		function void set_multiplier(logic [30:0] v);
			mult = v;
		endfunction

		function int pending();
			return expected_lanes.size();
		endfunction

		task report_mismatch(string what);
			if (errors < 100) $display("MISMATCH @%0t: %s", $realtime, what);
			errors++;
		endtask

		function void accept_command(op_t op, logic [63:0] v);
			logic [30:0] a;
			logic [30:0] s;
			logic [30:0] m;
			lane_vec_t   want;
			a = fold31({33'd0, mult});
			case (op)
				OP_SEED: begin
					s = fold31({32'd0, v[31:0]});
					if (s == 31'd0) s = 31'd1;
					for (int k = 0; k < LANES; k++) begin
						s = mulmod(s, a);
						lanes[k] = s;
					end
					jump_step = powmod(a, 64'd8);
					n_seed++;
				end
				OP_GEN: begin
					for (int k = 0; k < LANES; k++) begin
						want[k] = lanes[k];
						lanes[k] = mulmod(lanes[k], jump_step);
					end
					expected_lanes.push_back(want);
					n_gen++;
				end
				OP_SKIP: begin
					m = powmod(a, {v[60:0], 3'b000});
					for (int k = 0; k < LANES; k++) lanes[k] = mulmod(lanes[k], m);
					n_skip++;
				end
				default: n_ignored++;
			endcase
		endfunction

		task check_lanes(lane_vec_t got);
			lane_vec_t want;
			if (expected_lanes.size() == 0) begin
				report_mismatch("result transfer with nothing expected");
			end else begin
				want = expected_lanes.pop_front();
				for (int k = 0; k < LANES; k++)
					if (got[k] !== want[k])
						report_mismatch($sformatf("lane%0d got %0d want %0d", k, got[k],
							want[k]));
			end
		endtask
	endclass

	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 600;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [30:0] cfg_wdata;
	bit          calm;
	int          idle_cycles;
	int          n_settings;

	lrsa_item_if   item_ch ();
	lrsa_result_if res_ch ();

	lehmer_rng_eight_lane_skipahead dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.items     (item_ch),
		.results   (res_ch)
	);

	lehmer_scoreboard book;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_item(op_t op, logic [63:0] v);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		repeat (gap) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.operation <= op;
		item_ch.value <= v;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		book.accept_command(op, v);
	endtask

	task automatic release_items();
		item_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (book.pending() != 0) @(posedge clk);
	endtask

	task automatic write_multiplier(logic [30:0] v);
		release_items();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		book.set_multiplier(v);
		n_settings++;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic run_random(int count);
		int          done;
		int          r;
		logic [63:0] v;
		done = 0;
		while (done < count) begin
			r = $urandom_range(0, 99);
			v = rand64();
			if (done == count / 2) begin
				release_items();
				wait_drained();
			end
			if (r < 45) begin
				send_item(OP_GEN, v);
				done++;
			end else if (r < 62) begin
				case ($urandom_range(0, 9))
					0: v[31:0] = 32'h0000_0000;
					1: v[31:0] = 32'h7FFF_FFFF;
					2: v[31:0] = 32'hFFFF_FFFE;
					3: v[31:0] = 32'hFFFF_FFFF;
					default: ;
				endcase
				send_item(OP_SEED, v);
				done++;
			end else if (r < 92) begin
				case ($urandom_range(0, 19))
					0, 1, 2: v = {v[63:61], 61'd0};
					3, 4, 5, 6, 7: ;
					default: v = 64'($urandom_range(0, 40));
				endcase
				send_item(OP_SKIP, v);
				done++;
			end else begin
				send_item(OP_NONE, v);
			end
		end
	endtask

	initial begin
		res_ch.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin : stall_loop
			int stall;
			stall = calm ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin : monitor
		lane_vec_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = {res_ch.lane7, res_ch.lane6, res_ch.lane5, res_ch.lane4,
				res_ch.lane3, res_ch.lane2, res_ch.lane1, res_ch.lane0};
			book.check_lanes(got);
		end
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
			$display("tb_lehmer_rng_eight_lane_skipahead: errors");
			$finish;
		end
	end

	initial begin
		logic [30:0] phase_mult [0:6];
		int          phase_len  [0:6];
		book = new();
		calm = 1'b0;
		n_settings = 1;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 31'd0;
		item_ch.valid <= 1'b0;
		item_ch.operation <= OP_SEED;
		item_ch.value <= 64'd0;
		phase_mult[0] = 31'd16807;       phase_len[0] = 150;
		phase_mult[1] = 31'd1;           phase_len[1] = 150;
		phase_mult[2] = 31'h7FFF_FFFE;   phase_len[2] = 150;
		phase_mult[3] = 31'd0;           phase_len[3] = 30;
		phase_mult[4] = 31'h7FFF_FFFF;   phase_len[4] = 30;
		phase_mult[5] = 31'($urandom_range(2, 32'h7FFF_FFFD)); phase_len[5] = 150;
		phase_mult[6] = MULT_RESET;      phase_len[6] = 150;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: lanes at reset, seed corner values, skip corner offsets
		send_item(OP_GEN, 64'd0);
		send_item(OP_SKIP, 64'd5);
		send_item(OP_GEN, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(OP_SEED, 64'd0);
		send_item(OP_GEN, 64'd0);
		send_item(OP_SEED, 64'h0000_0000_7FFF_FFFF);
		send_item(OP_GEN, 64'd0);
		send_item(OP_SEED, 64'h0000_0000_FFFF_FFFE);
		send_item(OP_SEED, 64'h0000_0000_FFFF_FFFF);
		send_item(OP_GEN, 64'd0);
		send_item(OP_SEED, 64'hFFFF_FFFF_1234_5678);
		send_item(OP_GEN, 64'd0);
		send_item(OP_SKIP, 64'd0);
		send_item(OP_GEN, 64'd0);
		send_item(OP_SKIP, 64'h2000_0000_0000_0000);
		send_item(OP_GEN, 64'd0);
		send_item(OP_SKIP, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(OP_GEN, 64'd0);
		send_item(OP_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(OP_GEN, 64'd0);
		send_item(OP_SEED, 64'd1);
		send_item(OP_SKIP, 64'd1);
		send_item(OP_GEN, 64'd0);
		send_item(OP_GEN, 64'd0);
		send_item(OP_SKIP, 64'h8000_0000_0000_0000);
		send_item(OP_GEN, 64'd0);
		run_random(150);

		for (int phase = 0; phase < 7; phase++) begin
			write_multiplier(phase_mult[phase]);
			calm = (phase == 1 || phase == 5);
			// old jump multiplier still in force until the next seed
			send_item(OP_GEN, rand64());
			send_item(OP_SKIP, 64'($urandom_range(1, 9)));
			send_item(OP_GEN, rand64());
			run_random(phase_len[phase]);
		end

		release_items();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (book.pending() != 0)
			book.report_mismatch($sformatf("%0d results never arrived", book.pending()));
		$display("run covered %0d seeds, %0d generates, %0d skips, %0d ignored commands",
			book.n_seed, book.n_gen, book.n_skip, book.n_ignored);
		$display("over %0d multiplier settings; %0d mismatches", n_settings, book.errors);
		if (book.errors == 0)
			$display("tb_lehmer_rng_eight_lane_skipahead: clean");
		else
			$display("tb_lehmer_rng_eight_lane_skipahead: errors");
		$finish;
	end

endmodule
